// ===== rtl/gstcl_pkg.sv =====
// Shared types, constants and opcodes for the gradient stop color lookup unit.
package gstcl_pkg;

   localparam int MAX_STOPS_DEF = 16;
   localparam int POS_W = 17;
   localparam int COLOR_W = 24;
   localparam int IDX_IN_W = 4;
   localparam int COUNT_OUT_W = 5;
   localparam logic [POS_W-1:0] POS_ONE = 17'h10000;
   localparam logic [POS_W-1:0] POS_HALF = 17'h08000;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
   localparam int ENTRY_W = POS_W + COLOR_W;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_DELETE = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [POS_W-1:0]    position;
      logic [IDX_IN_W-1:0] stop_index;
   } req_type;

   typedef struct packed {
      logic [7:0]             red;
      logic [7:0]             green;
      logic [7:0]             blue;
      logic [COUNT_OUT_W-1:0] count_now;
      logic [1:0]             status;
   } rsp_type;

   // divider handshake between the sequencer and the divide unit
   typedef struct packed {
      logic        start;
      logic [25:0] dividend;
      logic [16:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic       done;
      logic [25:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_SCAN_LAST,
      S_RD_LO,
      S_RD_HI,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH,
      S_DEL_RD,
      S_DEL_WR,
      S_RESP
   } state_type;

endpackage

// ===== rtl/gradient_stop_table_color_lookup_unit.sv =====
// Gradient stop color lookup unit: stop table in RAM, scan sequencer, divider.
//
// Usage: the req_ channel carries one operation (lookup, add, delete) with a
// Q1.16 position and a slot index; the rsp_ channel returns one beat per
// request with the RGB color, the stop count after the operation and a status.
// One request is worked at a time. A lookup or add reads every stop once from
// the stop RAM (one stop per cycle); to interpolate it then reads the two
// bracket stops and runs three divisions, one per channel, on one divider.
// A delete moves each later stop down one slot, with a read state (S_DEL_RD)
// and a write state (S_DEL_WR) per stop. At reset the table holds three stops
// (0 black, 1.0 white, 0.5 green); they are written by a preload in S_INIT
// during which req_ready stays low. The result sits in an output register;
// while the receiver stalls the block holds it and takes no new request, and
// the next request may be accepted in the cycle after the result beat leaves.
module gradient_stop_table_color_lookup_unit #(
   parameter int MAX_STOPS = gstcl_pkg::MAX_STOPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gstcl_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gstcl_pkg::rsp_type rsp_data
);
   import gstcl_pkg::*;

   localparam int AW = $clog2(MAX_STOPS);
   localparam int CW = $clog2(MAX_STOPS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic [1:0]      op_ff, op_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic            match_ff, match_in, hlo_ff, hlo_in, hhi_ff, hhi_in;
   logic [AW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [POS_W-1:0] lx_ff, lx_in, hx_ff, hx_in;
   logic [COLOR_W-1:0] mc_ff, mc_in, lc_ff, lc_in, hc_ff, hc_in;
   logic [COLOR_W-1:0] col_ff, col_in;
   logic [1:0]      ch_ff, ch_in;
   logic [1:0]      stat_ff, stat_in;
   logic            rv_ff, rv_in;
   logic            scan_rd_ff, scan_rd_in;
   logic [AW-1:0]   scan_idx_ff, scan_idx_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [POS_W-1:0]  rd_pos;
   logic [COLOR_W-1:0] rd_col;
   logic [POS_W-1:0]  req_pos;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic [7:0]  lch, hch;
   logic [16:0] wa, wb;
   logic [25:0] prod_sum;
   logic [7:0]  qsat;
   logic        accept;

   gstcl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_STOPS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   gstcl_div u_div (
      .clock(clock),
      .reset(reset),
      .cmd  (div_cmd),
      .rsp  (div_rsp)
   );

   assign rd_pos = rd_data[ENTRY_W-1:COLOR_W];
   assign rd_col = rd_data[COLOR_W-1:0];
   assign req_pos = (req_data.position > POS_ONE) ? POS_ONE : req_data.position;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign accept = req_valid && req_ready;

   always_comb begin
      case (ch_ff)
         2'd0:    begin lch = lc_ff[23:16]; hch = hc_ff[23:16]; end
         2'd1:    begin lch = lc_ff[15:8];  hch = hc_ff[15:8];  end
         default: begin lch = lc_ff[7:0];   hch = hc_ff[7:0];   end
      endcase
      wa = pos_ff - lx_ff;
      wb = hx_ff - pos_ff;
      prod_sum = 26'(hch) * 26'(wa) + 26'(lch) * 26'(wb);
      qsat = (div_rsp.quotient > 26'd255) ? 8'hFF : div_rsp.quotient[7:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: if (ptr_ff == CW'(2)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_DELETE) begin
                  if (CW'(req_data.stop_index) >= count_ff ||
                      32'(req_data.stop_index) >= MAX_STOPS)
                     state_in = S_RESP;
                  else
                     state_in = S_DEL_RD;
               end else if (count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN:      if (ptr_ff >= count_ff) state_in = S_SCAN_LAST;
         S_SCAN_LAST: begin
            if (match_in || !hlo_in || !hhi_in) state_in = S_FINISH;
            else state_in = S_RD_LO;
         end
         S_RD_LO:     state_in = S_RD_HI;
         S_RD_HI:     state_in = S_DIV_START;
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) state_in = (ch_ff == 2'd2) ? S_FINISH : S_DIV_START;
         end
         S_FINISH:    state_in = S_RESP;
         S_DEL_RD:    state_in = (ptr_ff >= count_ff) ? S_RESP : S_DEL_WR;
         S_DEL_WR:    state_in = S_DEL_RD;
         S_RESP:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;  ptr_in = ptr_ff;  op_in = op_ff;  pos_in = pos_ff;
      match_in = match_ff;  hlo_in = hlo_ff;  hhi_in = hhi_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  lx_in = lx_ff;  hx_in = hx_ff;
      mc_in = mc_ff;  lc_in = lc_ff;  hc_in = hc_ff;  col_in = col_ff;
      ch_in = ch_ff;  stat_in = stat_ff;  rv_in = rv_ff;
      scan_rd_in = 1'b0;  scan_idx_in = scan_idx_ff;
      wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;  rd_addr = '0;
      div_cmd = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            case (ptr_ff[1:0])
               2'd0:    wr_data = {17'd0, COLOR_BLACK};
               2'd1:    wr_data = {POS_ONE, COLOR_WHITE};
               default: wr_data = {POS_HALF, COLOR_GREEN};
            endcase
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(2)) count_in = CW'(3);
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.operation;
               pos_in = req_pos;
               stat_in = ST_OK;
               col_in = '0;
               match_in = 1'b0;  hlo_in = 1'b0;  hhi_in = 1'b0;
               ch_in = 2'd0;
               if (req_data.operation == OP_DELETE) begin
                  if (CW'(req_data.stop_index) >= count_ff ||
                      32'(req_data.stop_index) >= MAX_STOPS)
                     stat_in = ST_RANGE;
                  ptr_in = CW'(req_data.stop_index) + CW'(1);
                  rd_addr = AW'(CW'(req_data.stop_index) + CW'(1));
               end else begin
                  rd_addr = '0;
                  ptr_in = CW'(1);
                  scan_rd_in = 1'b1;
                  scan_idx_in = '0;
               end
            end
         end
         S_SCAN, S_SCAN_LAST: begin
            if (state_ff == S_SCAN) begin
               rd_addr = ptr_ff[AW-1:0];
               if (ptr_ff < count_ff) begin
                  scan_rd_in = 1'b1;
                  scan_idx_in = ptr_ff[AW-1:0];
                  ptr_in = ptr_ff + CW'(1);
               end
            end
            if (scan_rd_ff && !match_ff) begin
               if (rd_pos == pos_ff) begin
                  match_in = 1'b1;  mc_in = rd_col;
               end
               if (rd_pos < pos_ff && (!hlo_ff || rd_pos > lx_ff)) begin
                  hlo_in = 1'b1;  lo_in = scan_idx_ff;  lx_in = rd_pos;  lc_in = rd_col;
               end
               if (rd_pos > pos_ff && (!hhi_ff || rd_pos < hx_ff)) begin
                  hhi_in = 1'b1;  hi_in = scan_idx_ff;  hx_in = rd_pos;  hc_in = rd_col;
               end
            end
            if (state_ff == S_SCAN_LAST) begin
               if (match_in) col_in = mc_in;
               else if (hlo_in && !hhi_in) col_in = lc_in;
               else if (!hlo_in && hhi_in) col_in = hc_in;
               else col_in = '0;
            end
         end
         S_RD_LO: rd_addr = lo_ff;
         S_RD_HI: rd_addr = hi_ff;
         S_DIV_START: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = prod_sum;
            div_cmd.divisor = hx_ff - lx_ff;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (ch_ff)
                  2'd0:    col_in[23:16] = qsat;
                  2'd1:    col_in[15:8]  = qsat;
                  default: col_in[7:0]   = qsat;
               endcase
               ch_in = ch_ff + 2'd1;
            end
         end
         S_FINISH: begin
            if (op_ff == OP_ADD) begin
               if (32'(count_ff) >= MAX_STOPS) begin
                  stat_in = ST_FULL;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = {pos_ff, col_ff};
                  count_in = count_ff + CW'(1);
               end
            end
         end
         S_DEL_RD: begin
            rd_addr = ptr_ff[AW-1:0];
            if (ptr_ff >= count_ff) count_in = count_ff - CW'(1);
         end
         S_DEL_WR: begin
            wr_en = 1'b1;
            wr_addr = AW'(ptr_ff - CW'(1));
            wr_data = rd_data;
            ptr_in = ptr_ff + CW'(1);
            rd_addr = AW'(ptr_ff + CW'(1));
         end
         S_RESP: rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= '0;
         ptr_ff   <= '0;
         rv_ff    <= 1'b0;
         scan_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         rv_ff    <= rv_in;
         scan_rd_ff <= scan_rd_in;
      end
      op_ff <= op_in;  pos_ff <= pos_in;
      match_ff <= match_in;  hlo_ff <= hlo_in;  hhi_ff <= hhi_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;
      lx_ff <= lx_in;  hx_ff <= hx_in;
      mc_ff <= mc_in;  lc_ff <= lc_in;  hc_ff <= hc_in;
      col_ff <= col_in;  ch_ff <= ch_in;  stat_ff <= stat_in;
      scan_idx_ff <= scan_idx_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data.red   = col_ff[23:16];
   assign rsp_data.green = col_ff[15:8];
   assign rsp_data.blue  = col_ff[7:0];
   assign rsp_data.count_now = COUNT_OUT_W'(count_ff);
   assign rsp_data.status = stat_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset) 32'(count_ff) <= MAX_STOPS)
      else $error("stop count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_START) |-> hx_ff > lx_ff)
      else $error("zero divisor");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RANGE |-> col_ff == '0)
      else $error("delete result carries color");
endmodule

// ===== rtl/gstcl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gstcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/gstcl_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module gstcl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gstcl_pkg::div_cmd_type cmd,
   output gstcl_pkg::div_rsp_type rsp
);
   import gstcl_pkg::*;

   localparam int QW = 26;
   localparam int DW = 17;

   logic [QW-1:0] quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 5'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[QW-1]} - {2'b00, dvs_ff};
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-1:0], quo_ff[QW-1]};
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) rsp.done |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) cmd.start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != 5'd0)
      else $error("divider count underflow");
endmodule
